// ----- design/gtsa_pkg.sv -----
`default_nettype none
package gtsa_pkg;

    localparam int SLOTS      = 16;
    localparam int TOKEN_BITS = 32;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);

    localparam logic [1:0] REQ_ACQUIRE  = 2'd0;
    localparam logic [1:0] REQ_RELEASE  = 2'd1;
    localparam logic [1:0] REQ_SHUTDOWN = 2'd2;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_STOPPED   = 3'd1;
    localparam logic [2:0] STAT_EXHAUSTED = 3'd2;
    localparam logic [2:0] STAT_BAD_ARG   = 3'd3;
    localparam logic [2:0] STAT_STALE     = 3'd4;
    localparam logic [2:0] STAT_ACTIVE    = 3'd5;

    typedef logic [TOKEN_BITS-1:0] token_t;
    typedef logic [SLOT_W-1:0]     slot_idx_t;
    typedef logic [CNT_W-1:0]      count_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  slot_number;
        logic [31:0] lease_token;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  granted_slot;
        logic [31:0] granted_token;
        logic [4:0]  active_slots;
    } out_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

endpackage
`default_nettype wire

// ----- design/gtsa_ctrl.sv -----
`default_nettype none
module gtsa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output gtsa_pkg::cmd_t     cmd,
    output logic               busy
);
    import gtsa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        busy        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = start;
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                busy        = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/gtsa_datapath.sv -----
`default_nettype none
module gtsa_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gtsa_pkg::cmd_t      cmd,
    input  wire gtsa_pkg::in_item_t  request,
    output logic                     done,
    output gtsa_pkg::out_item_t      result
);
    import gtsa_pkg::*;

    in_item_t  req_reg;
    token_t    gen_reg [SLOTS];
    token_t    gen_next [SLOTS];
    count_t    cnt_reg;
    count_t    cnt_next;
    logic      stopped_reg;
    logic      stopped_next;
    out_item_t res_reg;
    out_item_t res_next;
    logic      done_reg;

    logic [SLOTS-1:0] busy_vec;
    logic             any_free;
    slot_idx_t        first_free;
    slot_idx_t        addr;
    token_t           rd_tok;
    token_t           req_tok;
    token_t           inc_tok;

    // token bit 0 is the busy flag
    always_comb
    begin
        any_free   = 1'b0;
        first_free = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            busy_vec[i] = gen_reg[i][0];
            if (!gen_reg[i][0])
            begin
                any_free   = 1'b1;
                first_free = SLOT_W'(i);
            end
        end
    end

    assign req_tok = TOKEN_BITS'(req_reg.lease_token);
    assign addr    = (req_reg.req_type == REQ_ACQUIRE) ? first_free
                                                      : SLOT_W'(req_reg.slot_number);
    assign rd_tok  = gen_reg[addr];
    // acquire bumps the stored token, release bumps the presented one (equal on match)
    assign inc_tok = ((req_reg.req_type == REQ_ACQUIRE) ? rd_tok : req_tok) + 1'b1;

    always_comb
    begin
        gen_next     = gen_reg;
        cnt_next     = cnt_reg;
        stopped_next = stopped_reg;
        res_next     = '0;
        res_next.status = STAT_BAD_ARG;
        case (req_reg.req_type)
            REQ_ACQUIRE:
            begin
                if (stopped_reg)
                begin
                    res_next.status = STAT_STOPPED;
                end
                else if (!any_free)
                begin
                    res_next.status = STAT_EXHAUSTED;
                end
                else
                begin
                    gen_next[addr]         = inc_tok;
                    cnt_next               = cnt_reg + 1'b1;
                    res_next.status        = STAT_OK;
                    res_next.granted_slot  = 8'(addr);
                    res_next.granted_token = 32'(inc_tok);
                end
            end
            REQ_RELEASE:
            begin
                if (req_reg.slot_number >= 8'(SLOTS) || req_tok == '0)
                begin
                    res_next.status = STAT_BAD_ARG;
                end
                else if (rd_tok != req_tok || !req_tok[0])
                begin
                    res_next.status = STAT_STALE;
                end
                else
                begin
                    gen_next[addr] = inc_tok;
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                    res_next.status = STAT_OK;
                end
            end
            REQ_SHUTDOWN:
            begin
                if (!stopped_reg && cnt_reg != '0)
                begin
                    res_next.status = STAT_ACTIVE;
                end
                else
                begin
                    stopped_next    = 1'b1;
                    res_next.status = STAT_OK;
                end
            end
            default:
            begin
                res_next.status = STAT_BAD_ARG;
            end
        endcase
        res_next.active_slots = 5'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                gen_reg[i] <= '0;
            end
            cnt_reg     <= '0;
            stopped_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.execute;
            if (cmd.execute)
            begin
                gen_reg     <= gen_next;
                cnt_reg     <= cnt_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
        if (cmd.execute)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTHESIS
    a_count_matches_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(busy_vec) == int'(cnt_reg))
        else $error("busy count disagrees with busy slot flags");

    a_stopped_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> cnt_reg == '0)
        else $error("pool stopped with active slots");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cmd.execute))
        else $error("result strobe without an executed request");

    a_grant_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.status == STAT_OK && res_reg.granted_token != '0)
        |-> res_reg.granted_token[0])
        else $error("granted token is not odd");
`endif

endmodule
`default_nettype wire

// ----- design/generation_token_slot_allocator.sv -----
`default_nettype none
// Generation-token slot allocator: a pool of SLOTS slots, each with a token
// whose low bit marks it busy (odd) or free (even).
//
// Request channel: drive request (req_type, slot_number, lease_token) and
// raise start; the transfer happens at the rising edge where start is high
// and busy is low. busy is high for one cycle after each transfer.
//
// Result channel: one result per request. done pulses high for exactly one
// cycle once the captured request has been executed, with result (status,
// granted_slot, granted_token, active_slots) valid in that cycle. There is
// no backpressure; the receiver must take the result when done is high.
//
// Sequencing: the controller captures the request at the transfer edge and
// then executes it, holding busy high meanwhile; a priority encoder over the
// busy flags picks the lowest free slot and the token array is updated in
// the execute cycle. A new start is accepted in the cycle done is shown.
//
// Reset (rst_n low, asynchronous): all tokens zero (every slot free),
// active count zero, pool running, no result pending.
module generation_token_slot_allocator (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire gtsa_pkg::in_item_t  request,
    output logic                     done,
    output gtsa_pkg::out_item_t      result
);
    import gtsa_pkg::*;

    cmd_t cmd;

    // sequencing: capture then execute
    gtsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy)
    );

    // token store, busy count, stop flag and result register
    gtsa_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .done    (done),
        .result  (result)
    );

endmodule
`default_nettype wire
